### design/pfde_pkg.sv
// Package for the page framebuffer draw engine.
// Types, sizes, opcodes and FSM states shared by all design files; no dependencies.
`default_nettype none

package pfde_pkg;

    // Store geometry
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int PAGES       = (MAX_HEIGHT + 7) / 8;
    localparam int FRAME_DEPTH = MAX_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int PAGE_W      = $clog2(PAGES);
    localparam int CNT_W       = $clog2(MAX_WIDTH + 1);

    // Field widths fixed by the interface
    localparam int W_W   = 8;
    localparam int H_W   = 7;
    localparam int IDX_W = 2;

    // Opcodes
    localparam logic [2:0] OP_PUTPIXEL = 3'd0;
    localparam logic [2:0] OP_HLINE    = 3'd1;
    localparam logic [2:0] OP_VLINE    = 3'd2;
    localparam logic [2:0] OP_BLIT     = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] x_a;
        logic [7:0] x_b;
        logic [7:0] y_a;
        logic [7:0] y_b;
        logic       pixel_value;
        logic [7:0] src_byte;
        logic [3:0] src_len;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } out_item_t;

    // Frame store port controls
    typedef struct packed {
        logic              ren;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
    } mem_req_t;

    // Address unit controls
    typedef struct packed {
        logic              load;
        logic              step;
        logic [7:0]        x;
        logic [PAGE_W-1:0] page;
        logic [W_W-1:0]    width;
        logic [W_W-1:0]    incr;
    } addr_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_READ,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

### design/pfde_addr_unit.sv
// Address unit: one shared adder that loads x + page * width, then steps by incr.
// Depends on pfde_pkg.
`default_nettype none

module pfde_addr_unit
    import pfde_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire addr_cmd_t         cmd,
    output logic      [ADDR_W-1:0] addr
);

    logic [ADDR_W-1:0]        addr_reg;
    logic [ADDR_W-1:0]        addr_next;
    logic [PAGE_W+W_W-1:0]    prod;
    logic [ADDR_W-1:0]        op_a;
    logic [ADDR_W-1:0]        op_b;
    logic [ADDR_W-1:0]        sum;

    assign prod = (PAGE_W+W_W)'(cmd.page) * (PAGE_W+W_W)'(cmd.width);

    always_comb
    begin
        if (cmd.load)
        begin
            op_a = ADDR_W'(cmd.x);
            op_b = prod[ADDR_W-1:0];
        end
        else
        begin
            op_a = addr_reg;
            op_b = ADDR_W'(cmd.incr);
        end
        sum = op_a + op_b;
        addr_next = (cmd.load || cmd.step) ? sum : addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= '0;
        else
            addr_reg <= addr_next;
    end

    assign addr = addr_reg;

endmodule

`default_nettype wire

### design/pfde_frame_mem.sv
// Frame store: one write port and one read port with registered read data.
// Depends on pfde_pkg.
`default_nettype none

module pfde_frame_mem
    import pfde_pkg::*;
(
    input  wire logic       clk,
    input  wire mem_req_t   req,
    output logic      [7:0] rdata
);

    logic [7:0] mem [FRAME_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        if (req.ren)
            rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/page_framebuffer_draw_engine_unit.sv
// Top level of the page framebuffer draw engine: sequencer, config registers, output register.
// Depends on pfde_pkg, pfde_addr_unit and pfde_frame_mem.
//
// Monochrome drawing engine over a store of vertical bytes, one byte per column and 8-row
// page, bit 0 on top. Each accepted item (putpixel, hline, vline, blit byte, read byte)
// yields exactly one result item. After reset the engine sweeps the 1024-byte store to
// zero, one byte per cycle, and holds in_stall high while it does so; config writes
// are taken at any time (cfg_ready is tied high) but must only be issued while idle.
// Every store byte touched costs one read-modify-write over the frame store's two ports, and
// successive bytes overlap (the read of the next byte shares a cycle with the write of
// the previous one). An item touches at most one byte for putpixel, one per column drawn
// for hline, one per page for vline and up to two for blit; a read item reads its byte.
// In_stall stays high until the item's result is loaded into the output register; a
// result waiting there does not block the next item until that one finishes.
`default_nettype none

module page_framebuffer_draw_engine_unit
    import pfde_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // item input
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_item,
    // result output
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_item,
    // config writes
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [7:0]       cfg_data
);

    // ---------------------------------------------------------------- config registers
    logic [W_W-1:0] w_reg;
    logic [H_W-1:0] h_reg;
    logic [W_W-1:0] w_eff;
    logic [H_W-1:0] h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= W_W'(MAX_WIDTH);
            h_reg <= H_W'(MAX_HEIGHT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  w_reg <= cfg_data;
                REG_CANVAS_HEIGHT: h_reg <= cfg_data[H_W-1:0];
                default:           ;
            endcase
        end
    end

    // Saturate to 1..max so every access stays inside the store
    always_comb
    begin
        if (w_reg == '0)
            w_eff = W_W'(1);
        else if (w_reg > W_W'(MAX_WIDTH))
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = w_reg;

        if (h_reg == '0)
            h_eff = H_W'(1);
        else if (h_reg > H_W'(MAX_HEIGHT))
            h_eff = H_W'(MAX_HEIGHT);
        else
            h_eff = h_reg;
    end

    // ---------------------------------------------------------------- sequencer state
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    in_item_t           it_reg, it_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               first_reg, first_next;
    logic [7:0]         mid_reg, mid_next;
    logic [7:0]         mfirst_reg, mfirst_next;
    logic [7:0]         mlast_reg, mlast_next;
    logic [7:0]         dfirst_reg, dfirst_next;
    logic [7:0]         drest_reg, drest_next;
    logic [W_W-1:0]     incr_reg, incr_next;
    logic               clip_reg, clip_next;
    logic               rdok_reg, rdok_next;
    // write stage of the read-modify-write
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [7:0]         pend_mask_reg, pend_mask_next;
    logic [7:0]         pend_data_reg, pend_data_next;
    // output register
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    // ---------------------------------------------------------------- shared units
    addr_cmd_t          acmd;
    logic [ADDR_W-1:0]  addr;
    mem_req_t           mreq;
    logic [7:0]         rdata;

    pfde_addr_unit u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (acmd),
        .addr  (addr)
    );

    pfde_frame_mem u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    // ---------------------------------------------------------------- item setup
    // Decodes the registered item into a byte count, masks, data and start address.
    logic [7:0]         y_h;
    logic [7:0]         xa_c, xb_c, hx_lo, hx_hi;
    logic [7:0]         vy_lo, vy_hi;
    logic [3:0]         len_c;
    logic [8:0]         len_ones;
    logic [15:0]        m16, d16, valid16, wm16;
    logic [7:0]         base_row;
    logic [4:0]         read_pages;
    logic               x_in;

    logic [CNT_W-1:0]   s_cnt;
    logic               s_clip;
    logic               s_rdok;
    logic [7:0]         s_x;
    logic [PAGE_W-1:0]  s_page;
    logic [7:0]         s_mid, s_mfirst, s_mlast, s_dfirst, s_drest;
    logic [W_W-1:0]     s_incr;

    always_comb
    begin
        y_h   = {1'b0, h_eff};
        x_in  = it_reg.x_a < w_eff;

        // hline endpoints, clamped then ordered
        xa_c  = (it_reg.x_a >= w_eff) ? (w_eff - 8'd1) : it_reg.x_a;
        xb_c  = (it_reg.x_b >= w_eff) ? (w_eff - 8'd1) : it_reg.x_b;
        hx_lo = (xa_c > xb_c) ? xb_c : xa_c;
        hx_hi = (xa_c > xb_c) ? xa_c : xb_c;

        // vline endpoints, ordered
        vy_lo = (it_reg.y_b < it_reg.y_a) ? it_reg.y_b : it_reg.y_a;
        vy_hi = (it_reg.y_b < it_reg.y_a) ? it_reg.y_a : it_reg.y_b;

        // blit: source window over two pages, minus rows below the canvas
        len_c    = (it_reg.src_len > 4'd8) ? 4'd8 : it_reg.src_len;
        len_ones = (9'd1 << len_c) - 9'd1;
        m16      = {8'h00, len_ones[7:0]} << it_reg.y_a[2:0];
        d16      = {8'h00, it_reg.src_byte} << it_reg.y_a[2:0];
        base_row = {it_reg.y_a[7:3], 3'b000};
        for (int j = 0; j < 16; j++)
            valid16[j] = ({1'b0, base_row} + 9'(j)) < {2'b00, h_eff};
        wm16     = x_in ? (m16 & valid16) : 16'h0000;

        read_pages = 5'((h_eff + H_W'(7)) >> 3);

        s_cnt    = '0;
        s_clip   = 1'b0;
        s_rdok   = 1'b0;
        s_x      = it_reg.x_a;
        s_page   = it_reg.y_a[PAGE_W+2:3];
        s_mid    = 8'hFF;
        s_mfirst = 8'hFF;
        s_mlast  = 8'hFF;
        s_dfirst = {8{it_reg.pixel_value}};
        s_drest  = {8{it_reg.pixel_value}};
        s_incr   = w_eff;

        case (it_reg.opcode)
            OP_PUTPIXEL:
            begin
                s_mid = 8'h01 << it_reg.y_a[2:0];
                if (x_in && (it_reg.y_a < y_h))
                    s_cnt = CNT_W'(1);
                else
                    s_clip = 1'b1;
            end
            OP_HLINE:
            begin
                s_mid  = 8'h01 << it_reg.y_a[2:0];
                s_x    = hx_lo;
                s_incr = W_W'(1);
                s_clip = (it_reg.x_a >= w_eff) || (it_reg.x_b >= w_eff);
                if (it_reg.y_a < y_h)
                    s_cnt = CNT_W'(hx_hi - hx_lo) + CNT_W'(1);
                else
                    s_clip = 1'b1;
            end
            OP_VLINE:
            begin
                s_page   = vy_lo[PAGE_W+2:3];
                s_mfirst = 8'hFF << vy_lo[2:0];
                s_mlast  = 8'hFF >> (~vy_hi[2:0]);
                if (x_in && (it_reg.y_a < y_h) && (it_reg.y_b < y_h))
                    s_cnt = CNT_W'(vy_hi[7:3]) - CNT_W'(vy_lo[7:3]) + CNT_W'(1);
                else
                    s_clip = 1'b1;
            end
            OP_BLIT:
            begin
                s_mfirst = wm16[7:0];
                s_dfirst = d16[7:0];
                s_drest  = d16[15:8];
                s_clip   = (len_c != 4'd0) && (!x_in || ((m16 & ~valid16) != 16'h0000));
                if (wm16[15:8] != 8'h00)
                begin
                    s_cnt   = CNT_W'(2);
                    s_mlast = wm16[15:8];
                end
                else if (wm16[7:0] != 8'h00)
                    s_cnt = CNT_W'(1);
            end
            OP_READ:
            begin
                s_rdok = x_in && (it_reg.y_a[7:3] < read_pages);
                s_clip = !s_rdok;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            clip_reg      <= 1'b0;
            rdok_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            clip_reg      <= clip_next;
            rdok_reg      <= rdok_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg        <= it_next;
        mid_reg       <= mid_next;
        mfirst_reg    <= mfirst_next;
        mlast_reg     <= mlast_next;
        dfirst_reg    <= dfirst_next;
        drest_reg     <= drest_next;
        incr_reg      <= incr_next;
        pend_addr_reg <= pend_addr_next;
        pend_mask_reg <= pend_mask_next;
        pend_data_reg <= pend_data_next;
        out_item_reg  <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        it_next        = it_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        mid_next       = mid_reg;
        mfirst_next    = mfirst_reg;
        mlast_next     = mlast_reg;
        dfirst_next    = dfirst_reg;
        drest_next     = drest_reg;
        incr_next      = incr_reg;
        clip_next      = clip_reg;
        rdok_next      = rdok_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_mask_next = pend_mask_reg;
        pend_data_next = pend_data_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;

        acmd.load  = 1'b0;
        acmd.step  = 1'b0;
        acmd.x     = s_x;
        acmd.page  = s_page;
        acmd.width = w_eff;
        acmd.incr  = incr_reg;

        // write half of the read-modify-write, whenever a byte is pending
        mreq.ren   = 1'b0;
        mreq.raddr = addr;
        mreq.we    = pend_reg;
        mreq.waddr = pend_addr_reg;
        mreq.wdata = (rdata & ~pend_mask_reg) | (pend_data_reg & pend_mask_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = clr_reg;
                mreq.wdata = 8'h00;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(FRAME_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    it_next    = in_item;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                acmd.load   = 1'b1;
                cnt_next    = s_cnt;
                first_next  = 1'b1;
                mid_next    = s_mid;
                mfirst_next = s_mfirst;
                mlast_next  = s_mlast;
                dfirst_next = s_dfirst;
                drest_next  = s_drest;
                incr_next   = s_incr;
                clip_next   = s_clip;
                rdok_next   = s_rdok;
                state_next  = s_rdok ? ST_READ : ST_RUN;
            end
            ST_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    // read this byte, write it back next cycle
                    mreq.ren       = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = addr;
                    pend_mask_next = mid_reg
                                   & (first_reg ? mfirst_reg : 8'hFF)
                                   & ((cnt_reg == CNT_W'(1)) ? mlast_reg : 8'hFF);
                    pend_data_next = first_reg ? dfirst_reg : drest_reg;
                    acmd.step      = 1'b1;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    first_next     = 1'b0;
                end
                else
                    state_next = ST_FIN;
            end
            ST_READ:
            begin
                mreq.ren   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.read_data = rdok_reg ? rdata : 8'h00;
                    out_item_next.clipped   = clip_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire
